// File: sv/ahia_pkg.sv
// ----------------------------------------------------------------------------
// ahia_pkg
// shared types and constants of the aliased heap interval allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ahia_pkg;

    localparam int ADDR_W              = 40;
    localparam int PASS_W              = 8;
    localparam int ID_W                = 8;
    localparam int ALIGN_W             = 6;
    localparam int DEFAULT_MAX_BUCKETS = 32;
    localparam int DEFAULT_MAX_PASSES  = 256;

    localparam logic [ADDR_W-1:0]  HEAP_MAX  = {ADDR_W{1'b1}};
    localparam logic [ALIGN_W-1:0] ALIGN_BIG = ALIGN_W'(ADDR_W);

    typedef struct packed {
        logic               start_frame;
        logic [ID_W-1:0]    resource_id;
        logic [PASS_W-1:0]  first_use;
        logic [PASS_W-1:0]  last_use;
        logic [ADDR_W-1:0]  alloc_size;
        logic [ALIGN_W-1:0] align_log2;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_offset;
        logic              reused;
        logic              alias_valid;
        logic [ID_W-1:0]   alias_prev;
        logic [ADDR_W-1:0] heap_size;
        logic              overflow;
    } t_res;

    // request fields broadcast to every cell during a scan
    typedef struct packed {
        logic [PASS_W-1:0] first_use;
        logic [PASS_W-1:0] last_use;
        logic [ID_W-1:0]   resource_id;
        logic [ADDR_W-1:0] alloc_size;
        logic [ADDR_W-1:0] amask;
    } t_scan;

    // token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [ADDR_W-1:0] heap_offset;
        logic [ID_W-1:0]   owner;
    } t_tok;

    // new bucket write
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] heap_offset;
        logic [ADDR_W-1:0] alloc_size;
    } t_wr;

endpackage

`default_nettype wire

// File: sv/aliased_heap_interval_allocator.sv
// ----------------------------------------------------------------------------
// aliased_heap_interval_allocator
// first-fit reuse of heap regions by lifetime, bump allocation on a miss
// ----------------------------------------------------------------------------
// a reuse ends with the scan; a miss goes on to the S_BUMP state before o_done
// one request at a time, busy high from accept until o_done
// the scan token walks the bucket cell chain one cell per cycle
// reset clears bucket count and heap top; bucket contents are not cleared
// o_done is a one-cycle strobe, the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module aliased_heap_interval_allocator #(
    parameter int MAX_BUCKETS = ahia_pkg::DEFAULT_MAX_BUCKETS,
    parameter int MAX_PASSES  = ahia_pkg::DEFAULT_MAX_PASSES
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  ahia_pkg::t_req i_req,
    output logic           o_done,
    output ahia_pkg::t_res o_res
);
    import ahia_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam int IDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PCMP_W = 13;
    localparam logic [PCMP_W-1:0] PASS_LIM = PCMP_W'(MAX_PASSES);
    localparam logic [PCMP_W-1:0] PASS_TOP = PCMP_W'(MAX_PASSES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_BUMP
    } t_state;

    t_state            r_state;
    t_scan             r_scan;
    logic [ALIGN_W-1:0] r_align;
    logic              r_inject;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_heap_top;
    logic [ADDR_W:0]   r_off;
    logic              r_pre_ovf;

    t_tok              w_tok [MAX_BUCKETS+1];
    t_wr               w_wr;
    logic              w_accept;
    logic [PASS_W-1:0] w_fu;
    logic [PASS_W-1:0] w_lu;
    logic [ADDR_W-1:0] w_amask;
    logic [ADDR_W:0]   n_off;
    logic              n_pre_ovf;
    logic [ADDR_W+1:0] w_end;
    logic              w_rng_ovf;
    logic              w_full;
    logic [ADDR_W-1:0] w_sat_off;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // pass clamp and alignment mask
    always_comb begin
        w_fu = ({{(PCMP_W-PASS_W){1'b0}}, i_req.first_use} < PASS_LIM)
               ? i_req.first_use : PASS_TOP[PASS_W-1:0];
        w_lu = ({{(PCMP_W-PASS_W){1'b0}}, i_req.last_use} < PASS_LIM)
               ? i_req.last_use : PASS_TOP[PASS_W-1:0];
        if (i_req.align_log2 >= ALIGN_BIG) begin
            w_amask = HEAP_MAX;
        end else begin
            w_amask = ~(HEAP_MAX << i_req.align_log2);
        end
    end

    // aligned heap top
    always_comb begin
        if (r_align >= ALIGN_BIG) begin
            n_pre_ovf = (r_heap_top != '0);
            n_off     = n_pre_ovf ? {1'b0, HEAP_MAX} : '0;
        end else begin
            n_pre_ovf = 1'b0;
            n_off     = ({1'b0, r_heap_top} + {1'b0, r_scan.amask})
                        & ~{1'b0, r_scan.amask};
        end
    end

    // bump step
    always_comb begin
        w_end     = {1'b0, r_off} + {2'b00, r_scan.alloc_size};
        w_rng_ovf = r_pre_ovf || r_off[ADDR_W] || (w_end[ADDR_W+1:ADDR_W] != 2'b00);
        w_full    = (r_count >= CNT_W'(MAX_BUCKETS));
        w_sat_off = r_off[ADDR_W] ? HEAP_MAX : r_off[ADDR_W-1:0];
        w_wr.en          = (r_state == S_BUMP) && !w_rng_ovf && !w_full;
        w_wr.heap_offset = r_off[ADDR_W-1:0];
        w_wr.alloc_size  = r_scan.alloc_size;
    end

    always_comb begin
        w_tok[0].valid       = r_inject;
        w_tok[0].hit         = 1'b0;
        w_tok[0].heap_offset = '0;
        w_tok[0].owner       = '0;
    end

    for (genvar g = 0; g < MAX_BUCKETS; g++) begin : g_cell
        ahia_cell #(
            .MAX_BUCKETS (MAX_BUCKETS),
            .IDX         (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1]),
            .i_scan   (r_scan),
            .i_count  (r_count),
            .i_wr     (w_wr),
            .i_wr_idx (r_count[IDX_W-1:0])
        );
    end

    always_ff @(posedge i_clk) begin
        r_off     <= n_off;
        r_pre_ovf <= n_pre_ovf;
        if (w_accept) begin
            r_scan.first_use   <= w_fu;
            r_scan.last_use    <= w_lu;
            r_scan.resource_id <= i_req.resource_id;
            r_scan.alloc_size  <= i_req.alloc_size;
            r_scan.amask       <= w_amask;
            r_align            <= i_req.align_log2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_inject   <= 1'b0;
            r_count    <= '0;
            r_heap_top <= '0;
            o_done     <= 1'b0;
            o_res      <= '0;
        end else begin
            r_inject <= 1'b0;
            o_done   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_inject <= 1'b1;
                        r_state  <= S_SCAN;
                        if (i_req.start_frame) begin
                            r_count    <= '0;
                            r_heap_top <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_tok[MAX_BUCKETS].valid) begin
                        if (w_tok[MAX_BUCKETS].hit) begin
                            o_done            <= 1'b1;
                            o_res.heap_offset <= w_tok[MAX_BUCKETS].heap_offset;
                            o_res.reused      <= 1'b1;
                            o_res.alias_valid <= 1'b1;
                            o_res.alias_prev  <= w_tok[MAX_BUCKETS].owner;
                            o_res.heap_size   <= r_heap_top;
                            o_res.overflow    <= 1'b0;
                            r_state           <= S_IDLE;
                        end else begin
                            r_state <= S_BUMP;
                        end
                    end
                end
                S_BUMP: begin
                    o_done            <= 1'b1;
                    o_res.heap_offset <= w_sat_off;
                    o_res.reused      <= 1'b0;
                    o_res.alias_valid <= 1'b0;
                    o_res.alias_prev  <= '0;
                    if (w_rng_ovf) begin
                        r_heap_top      <= HEAP_MAX;
                        o_res.heap_size <= HEAP_MAX;
                        o_res.overflow  <= 1'b1;
                    end else begin
                        r_heap_top      <= w_end[ADDR_W-1:0];
                        o_res.heap_size <= w_end[ADDR_W-1:0];
                        o_res.overflow  <= w_full;
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BUCKETS))
        else $error("bucket count beyond table depth");

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a request in flight");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    a_reuse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.reused) |-> (o_res.alias_valid && !o_res.overflow))
        else $error("reuse beat with overflow or without alias");

    a_token_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_tok[MAX_BUCKETS].valid && w_tok[MAX_BUCKETS].hit)
        |=> o_done)
        else $error("hit token did not produce a result beat");

endmodule

`default_nettype wire

// File: sv/ahia_cell.sv
// ----------------------------------------------------------------------------
// ahia_cell
// one bucket of the table; checks the passing token first-fit and hands it on
// ----------------------------------------------------------------------------
`default_nettype none

module ahia_cell #(
    parameter int MAX_BUCKETS = ahia_pkg::DEFAULT_MAX_BUCKETS,
    parameter int IDX         = 0,
    localparam int CNT_W      = $clog2(MAX_BUCKETS + 1),
    localparam int IDX_W      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ahia_pkg::t_tok       i_tok,
    output ahia_pkg::t_tok       o_tok,
    input  ahia_pkg::t_scan      i_scan,
    input  wire [CNT_W-1:0]      i_count,
    input  ahia_pkg::t_wr        i_wr,
    input  wire [IDX_W-1:0]      i_wr_idx
);
    import ahia_pkg::*;

    logic [ADDR_W-1:0] r_off;
    logic [ADDR_W-1:0] r_size;
    logic [PASS_W-1:0] r_lu;
    logic [ID_W-1:0]   r_own;
    logic              r_vld;
    logic              r_hit;
    logic [ADDR_W-1:0] r_tok_off;
    logic [ID_W-1:0]   r_tok_own;
    logic              w_live;
    logic              w_match;

    assign w_live  = CNT_W'(IDX) < i_count;
    assign w_match = i_tok.valid && !i_tok.hit && w_live
                     && (r_lu < i_scan.first_use)
                     && (r_size >= i_scan.alloc_size)
                     && ((r_off & i_scan.amask) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= i_tok.hit | w_match;
        if (w_match) begin
            r_tok_off <= r_off;
            r_tok_own <= r_own;
        end else begin
            r_tok_off <= i_tok.heap_offset;
            r_tok_own <= i_tok.owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match) begin
            r_lu  <= i_scan.last_use;
            r_own <= i_scan.resource_id;
        end else if (i_wr.en && (i_wr_idx == IDX_W'(IDX))) begin
            r_off  <= i_wr.heap_offset;
            r_size <= i_wr.alloc_size;
            r_lu   <= i_scan.last_use;
            r_own  <= i_scan.resource_id;
        end
    end

    always_comb begin
        o_tok.valid       = r_vld;
        o_tok.hit         = r_hit;
        o_tok.heap_offset = r_tok_off;
        o_tok.owner       = r_tok_own;
    end

endmodule

`default_nettype wire
